### hw/rtl/sqe_pkg.sv
// shared types, constants and escape table for the shell quote escaper
package sqe_pkg;

   localparam int MaxBytes   = 8;
   localparam int IdxWidth   = $clog2(MaxBytes);
   localparam int QueueDepth = 2;
   localparam int PtrWidth   = $clog2(QueueDepth);
   localparam int CntWidth   = $clog2(QueueDepth + 1);

   localparam logic [7:0] CharQuote     = 8'h27;
   localparam logic [7:0] CharBackslash = 8'h5C;
   localparam logic [7:0] CharDollar    = 8'h24;
   localparam logic [7:0] CharZero      = 8'h30;
   localparam logic [7:0] PrintLow      = 8'h20;
   localparam logic [7:0] PrintHigh     = 8'h7E;

   typedef enum logic [2:0] {
      MODE_OUTSIDE = 3'b001,
      MODE_PLAIN   = 3'b010,
      MODE_ANSI    = 3'b100
   } mode_type;

   typedef struct packed {
      logic [MaxBytes-1:0][7:0] bytes;
      logic [IdxWidth-1:0]      last_idx;
   } entry_type;

   // letter after the backslash, zero when the byte needs octal
   function automatic logic [7:0] short_escape(input logic [7:0] c);
      logic [7:0] e;
      unique case (c)
         8'h5C:   e = 8'h5C;
         8'h27:   e = 8'h27;
         8'h07:   e = 8'h61;
         8'h08:   e = 8'h62;
         8'h1B:   e = 8'h65;
         8'h0C:   e = 8'h66;
         8'h0A:   e = 8'h6E;
         8'h0D:   e = 8'h72;
         8'h09:   e = 8'h74;
         8'h0B:   e = 8'h76;
         default: e = 8'h00;
      endcase
      return e;
   endfunction

endpackage

### hw/rtl/sqe_front.sv
// front end: takes input beats, tracks the quote mode and builds the byte sequence
module sqe_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,  // char_code
   input  logic                  req_tuser,  // char_valid
   input  logic                  req_tlast,  // end_of_text
   output logic                  push,
   output sqe_pkg::entry_type    push_entry,
   input  logic                  queue_ready
);

   sqe_pkg::mode_type                  mode_ff;
   sqe_pkg::mode_type                  mode_in;
   logic [sqe_pkg::MaxBytes-1:0][7:0]  seq;
   logic [sqe_pkg::IdxWidth:0]         n;
   logic [7:0]                         esc;
   logic                               plain;
   logic                               accept;

   assign req_tready = queue_ready;
   assign accept     = req_tvalid && req_tready;
   assign esc        = sqe_pkg::short_escape(req_tdata);
   assign plain      = (req_tdata >= sqe_pkg::PrintLow) && (req_tdata <= sqe_pkg::PrintHigh)
                       && (req_tdata != sqe_pkg::CharBackslash)
                       && (req_tdata != sqe_pkg::CharQuote);

   always_comb begin
      seq     = '0;
      n       = '0;
      mode_in = mode_ff;
      if (req_tuser) begin
         if (plain) begin
            unique case (mode_ff)
               sqe_pkg::MODE_ANSI: begin
                  seq[n[sqe_pkg::IdxWidth-1:0]] = sqe_pkg::CharQuote;
                  n = n + 1'b1;
                  seq[n[sqe_pkg::IdxWidth-1:0]] = sqe_pkg::CharQuote;
                  n = n + 1'b1;
               end
               sqe_pkg::MODE_PLAIN: begin
               end
               default: begin
                  seq[n[sqe_pkg::IdxWidth-1:0]] = sqe_pkg::CharQuote;
                  n = n + 1'b1;
               end
            endcase
            mode_in = sqe_pkg::MODE_PLAIN;
            seq[n[sqe_pkg::IdxWidth-1:0]] = req_tdata;
            n = n + 1'b1;
         end else begin
            if (mode_ff == sqe_pkg::MODE_PLAIN) begin
               seq[n[sqe_pkg::IdxWidth-1:0]] = sqe_pkg::CharQuote;
               n = n + 1'b1;
            end
            if (mode_ff != sqe_pkg::MODE_ANSI) begin
               seq[n[sqe_pkg::IdxWidth-1:0]] = sqe_pkg::CharDollar;
               n = n + 1'b1;
               seq[n[sqe_pkg::IdxWidth-1:0]] = sqe_pkg::CharQuote;
               n = n + 1'b1;
            end
            mode_in = sqe_pkg::MODE_ANSI;
            seq[n[sqe_pkg::IdxWidth-1:0]] = sqe_pkg::CharBackslash;
            n = n + 1'b1;
            if (esc != 8'h00) begin
               seq[n[sqe_pkg::IdxWidth-1:0]] = esc;
               n = n + 1'b1;
            end else begin
               seq[n[sqe_pkg::IdxWidth-1:0]] = sqe_pkg::CharZero + {6'b0, req_tdata[7:6]};
               n = n + 1'b1;
               seq[n[sqe_pkg::IdxWidth-1:0]] = sqe_pkg::CharZero + {5'b0, req_tdata[5:3]};
               n = n + 1'b1;
               seq[n[sqe_pkg::IdxWidth-1:0]] = sqe_pkg::CharZero + {5'b0, req_tdata[2:0]};
               n = n + 1'b1;
            end
         end
      end
      if (req_tlast) begin
         if (mode_in == sqe_pkg::MODE_OUTSIDE) begin
            seq[n[sqe_pkg::IdxWidth-1:0]] = sqe_pkg::CharQuote;
            n = n + 1'b1;
         end
         seq[n[sqe_pkg::IdxWidth-1:0]] = sqe_pkg::CharQuote;
         n = n + 1'b1;
         mode_in = sqe_pkg::MODE_OUTSIDE;
      end
   end

   assign push                = accept && (n != '0);
   assign push_entry.bytes    = seq;
   assign push_entry.last_idx = sqe_pkg::IdxWidth'(n - 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= sqe_pkg::MODE_OUTSIDE;
      end else if (accept) begin
         mode_ff <= mode_in;
      end
   end

endmodule

### hw/rtl/sqe_queue.sv
// short queue of byte sequences between front and back end
module sqe_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sqe_pkg::entry_type  push_entry,
   output logic                push_ready,
   input  logic                pop,
   output logic                head_valid,
   output sqe_pkg::entry_type  head_entry
);

   sqe_pkg::entry_type              mem_ff [sqe_pkg::QueueDepth];
   logic [sqe_pkg::PtrWidth-1:0]    wr_ptr_ff;
   logic [sqe_pkg::PtrWidth-1:0]    rd_ptr_ff;
   logic [sqe_pkg::CntWidth-1:0]    count_ff;
   logic [sqe_pkg::CntWidth-1:0]    count_in;

   assign push_ready = count_ff != sqe_pkg::CntWidth'(sqe_pkg::QueueDepth);
   assign head_valid = count_ff != '0;
   assign head_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= sqe_pkg::CntWidth'(sqe_pkg::QueueDepth))
      else $error("queue count beyond depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (push_ready || pop))
      else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");
`endif

endmodule

### hw/rtl/sqe_back.sv
// back end: sends the queued byte sequences one beat at a time
module sqe_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  sqe_pkg::entry_type  head_entry,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,  // out_byte
   output logic                rsp_tlast   // last
);

   logic [sqe_pkg::IdxWidth-1:0] idx_ff;
   logic [sqe_pkg::IdxWidth-1:0] idx_in;
   logic                         fire;

   assign rsp_tvalid = head_valid;
   assign rsp_tdata  = head_entry.bytes[idx_ff];
   assign rsp_tlast  = idx_ff == head_entry.last_idx;
   assign fire       = rsp_tvalid && rsp_tready;
   assign pop        = fire && rsp_tlast;

   always_comb begin
      idx_in = idx_ff;
      if (fire) begin
         idx_in = rsp_tlast ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

### hw/rtl/shell_quote_escaper_unit.sv
// top level of the shell quote escaper
// Quotes a byte stream as a bash word built from '...' and $'...' spans. Each
// input beat carries one text byte (req_tuser marks it as present) and
// req_tlast closes the word. A beat gives between zero and eight output
// bytes, and rsp_tlast marks the final byte of each beat's group. Input
// beats are taken one per cycle while the two-entry queue between the
// classifying front end and the output sequencer has room; the output side
// sends one byte per cycle while rsp_tready is high; a beat yields one byte
// for a plain printable byte inside '...' and up to eight for an octal
// escape with a quote switch and end of text.
module shell_quote_escaper_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // char_code
   input  logic       req_tuser,   // char_valid
   input  logic       req_tlast,   // end_of_text
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte
   output logic       rsp_tlast    // last
);

   logic               push;
   logic               push_ready;
   logic               pop;
   logic               head_valid;
   sqe_pkg::entry_type push_entry;
   sqe_pkg::entry_type head_entry;

   sqe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .push        (push),
      .push_entry  (push_entry),
      .queue_ready (push_ready)
   );

   sqe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   sqe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### tb/shell_quote_escaper_unit_test.sv
// testbench for the shell quote escaper: directed and random texts against a byte-level predictor
`timescale 1ns / 1ps

module shell_quote_escaper_unit_test;

   typedef struct {
      logic [7:0] code;
      logic       present;
      logic       closes;
   } text_item_type;

   typedef struct {
      logic [7:0] code;
      logic       last;
   } quoted_byte_type;

   localparam int RandomItems = 230;
   localparam int TailCycles  = 20;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // char_code
   logic       req_tuser = 1'b0;    // char_valid
   logic       req_tlast = 1'b0;    // end_of_text
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // out_byte
   logic       rsp_tlast;           // last

   text_item_type      pending_items [$];
   quoted_byte_type    expected_bytes [$];
   sqe_pkg::mode_type  quote_state = sqe_pkg::MODE_OUTSIDE;
   int                 fail_count = 0;

   logic [7:0] control_codes [8] = '{8'h07, 8'h08, 8'h1B, 8'h0C, 8'h0A, 8'h0D, 8'h09, 8'h0B};

   shell_quote_escaper_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] escape_letter(input logic [7:0] c);
      case (c)
         sqe_pkg::CharBackslash: return sqe_pkg::CharBackslash;
         sqe_pkg::CharQuote:     return sqe_pkg::CharQuote;
         8'h07:                  return "a";
         8'h08:                  return "b";
         8'h1B:                  return "e";
         8'h0C:                  return "f";
         8'h0A:                  return "n";
         8'h0D:                  return "r";
         8'h09:                  return "t";
         8'h0B:                  return "v";
         default:                return 8'h00;
      endcase
   endfunction

   task automatic predict_quoting(input text_item_type it);
      logic [7:0] seq [$];
      logic [7:0] letter;
      logic       is_plain;
      seq = {};
      if (it.present) begin
         is_plain = it.code >= sqe_pkg::PrintLow && it.code <= sqe_pkg::PrintHigh &&
                    it.code != sqe_pkg::CharBackslash && it.code != sqe_pkg::CharQuote;
         if (is_plain) begin
            if (quote_state != sqe_pkg::MODE_PLAIN) seq.push_back(sqe_pkg::CharQuote);
            if (quote_state == sqe_pkg::MODE_ANSI) seq.push_back(sqe_pkg::CharQuote);
            quote_state = sqe_pkg::MODE_PLAIN;
            seq.push_back(it.code);
         end else begin
            if (quote_state == sqe_pkg::MODE_PLAIN) seq.push_back(sqe_pkg::CharQuote);
            if (quote_state != sqe_pkg::MODE_ANSI) begin
               seq.push_back(sqe_pkg::CharDollar);
               seq.push_back(sqe_pkg::CharQuote);
            end
            quote_state = sqe_pkg::MODE_ANSI;
            letter = escape_letter(it.code);
            seq.push_back(sqe_pkg::CharBackslash);
            if (letter != 8'h00) begin
               seq.push_back(letter);
            end else begin
               seq.push_back(sqe_pkg::CharZero + {6'b0, it.code[7:6]});
               seq.push_back(sqe_pkg::CharZero + {5'b0, it.code[5:3]});
               seq.push_back(sqe_pkg::CharZero + {5'b0, it.code[2:0]});
            end
         end
      end
      if (it.closes) begin
         if (quote_state == sqe_pkg::MODE_OUTSIDE) seq.push_back(sqe_pkg::CharQuote);
         seq.push_back(sqe_pkg::CharQuote);
         quote_state = sqe_pkg::MODE_OUTSIDE;
      end
      foreach (seq[i]) expected_bytes.push_back('{seq[i], i == seq.size() - 1});
   endtask

   task automatic add_item(input logic [7:0] code, input logic present, input logic closes);
      pending_items.push_back('{code, present, closes});
   endtask

   function automatic logic [7:0] pick_text_byte();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return 8'($urandom_range(8'h20, 8'h7E));
         5:             return $urandom_range(0, 1) ? sqe_pkg::CharQuote
                                                    : sqe_pkg::CharBackslash;
         6:             return control_codes[$urandom_range(0, 7)];
         default:       return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // sender: bursts of random length separated by random gaps
   int            burst_left = 0;
   int            gap_left = 0;
   text_item_type on_bus;

   always @(posedge clock) begin : sender
      logic take;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_quoting(on_bus);
         if (!req_tvalid || req_tready) begin
            take = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_items.size() > 0) begin
               take = 1'b1;
               on_bus = pending_items.pop_front();
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                           : $urandom_range(0, 11);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
               end
            end
            req_tvalid <= take;
            if (take) begin
               req_tdata <= on_bus.code;
               req_tuser <= on_bus.present;
               req_tlast <= on_bus.closes;
            end
         end
      end
   end

   // receiver: stall pattern switches between free running, random and sparse
   int stall_kind = 0;
   int stall_left = 0;
   int stall_phase = 0;

   always @(posedge clock) begin : receiver
      logic ready;
      if (stall_left == 0) begin
         stall_kind = $urandom_range(0, 3);
         stall_left = $urandom_range(64, 256);
      end else begin
         stall_left--;
      end
      stall_phase++;
      case (stall_kind)
         0:       ready = 1'b1;
         1:       ready = $urandom_range(0, 1) == 1;
         2:       ready = (stall_phase % 4) == 0;
         default: ready = $urandom_range(0, 7) == 0;
      endcase
      rsp_tready <= reset ? 1'b0 : ready;
   end

   always @(posedge clock) begin : monitor
      quoted_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_bytes.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected beat: byte %h last %b", rsp_tdata, rsp_tlast);
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_tdata !== want.code || rsp_tlast !== want.last) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("mismatch: expected byte %h last %b, got byte %h last %b",
                           want.code, want.last, rsp_tdata, rsp_tlast);
            end
         end
      end
   end

   initial begin : stimulus
      int counted;
      int len;
      logic [7:0] code;
      // empty text, idle beat, plain printable edges
      add_item(8'h00, 1'b0, 1'b1);
      add_item(8'hA5, 1'b0, 1'b0);
      add_item("A", 1'b1, 1'b0);
      add_item(8'h7E, 1'b1, 1'b0);
      add_item(8'h20, 1'b1, 1'b0);
      // switch into $'...' and every short escape
      add_item(sqe_pkg::CharBackslash, 1'b1, 1'b0);
      add_item(sqe_pkg::CharQuote, 1'b1, 1'b0);
      foreach (control_codes[i]) add_item(control_codes[i], 1'b1, 1'b0);
      // octal escapes including high bytes
      add_item(8'h00, 1'b1, 1'b0);
      add_item(8'hFF, 1'b1, 1'b0);
      add_item(8'h7F, 1'b1, 1'b0);
      add_item(8'h80, 1'b1, 1'b0);
      add_item(8'h1F, 1'b1, 1'b0);
      add_item("z", 1'b1, 1'b1);
      add_item("A", 1'b1, 1'b1);
      // longest group: octal from inside '...' with end of text
      add_item("q", 1'b1, 1'b0);
      add_item(8'hC3, 1'b1, 1'b1);
      add_item(sqe_pkg::CharBackslash, 1'b1, 1'b1);
      add_item(8'h5A, 1'b0, 1'b1);

      counted = 0;
      while (counted < RandomItems) begin
         len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            code = pick_text_byte();
            add_item(code, 1'b1, i == len - 1 && $urandom_range(0, 1) == 1);
            counted++;
         end
         if (len == 0 || !pending_items[$].closes) begin
            add_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            counted++;
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      while (pending_items.size() > 0 || req_tvalid) @(negedge clock);
      while (expected_bytes.size() > 0) @(negedge clock);
      repeat (TailCycles) @(negedge clock);
      if (fail_count == 0 && expected_bytes.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin : watchdog
      #2ms;
      $display("simulation failed");
      $finish;
   end

endmodule
